/* src/mpbk_pkg.sv */
// ----------------------------------------------------------------------------
// mpbk_pkg
// Shared types, codes, symbol tables and the control program of the
// pulse-burst Morse keyer.
// ----------------------------------------------------------------------------
package mpbk_pkg;

    localparam int MPBK_TIME_BITS = 16;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int DIV_STEPS   = 16;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_DOT    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DASH   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_EGAP   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_WGAP   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PHIGH  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_PLOW   = 3'd5;

    localparam logic [15:0] RST_DOT   = 16'd50;
    localparam logic [15:0] RST_DASH  = 16'd350;
    localparam logic [15:0] RST_EGAP  = 16'd100;
    localparam logic [15:0] RST_WGAP  = 16'd350;
    localparam logic [7:0]  RST_PHIGH = 8'd2;
    localparam logic [7:0]  RST_PLOW  = 8'd3;

    // item functions
    localparam logic [1:0] FN_TICK  = 2'd0;
    localparam logic [1:0] FN_CHAR  = 2'd1;
    localparam logic [1:0] FN_DIGIT = 2'd2;

    // keying phases
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_HIGH = 3'd1;
    localparam logic [2:0] PH_LOW  = 3'd2;
    localparam logic [2:0] PH_EGAP = 3'd3;
    localparam logic [2:0] PH_WGAP = 3'd4;

    // characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LZ    = CH_LA + 8'd25;
    localparam logic [7:0] CH_UZ    = CH_UA + 8'd25;
    localparam logic [7:0] DIGIT_MAX = 8'd9;
    localparam logic [2:0] DIGIT_LEN = 3'd5;

    localparam logic [2:0] LETTER_LEN [26] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };
    localparam logic [4:0] LETTER_PAT [26] = '{
        5'd2, 5'd1, 5'd5, 5'd1, 5'd0, 5'd4, 5'd3, 5'd0, 5'd0, 5'd14, 5'd5, 5'd2, 5'd3,
        5'd1, 5'd7, 5'd6, 5'd11, 5'd2, 5'd0, 5'd1, 5'd4, 5'd8, 5'd6, 5'd9, 5'd13, 5'd3
    };
    localparam logic [4:0] DIGIT_PAT [10] = '{
        5'd31, 5'd30, 5'd28, 5'd24, 5'd16, 5'd0, 5'd1, 5'd3, 5'd7, 5'd15
    };

    // micro-operations
    localparam logic [2:0] OP_NONE      = 3'd0;
    localparam logic [2:0] OP_TAKE      = 3'd1;
    localparam logic [2:0] OP_DECODE    = 3'd2;
    localparam logic [2:0] OP_DIV_INIT  = 3'd3;
    localparam logic [2:0] OP_DIV_STEP  = 3'd4;
    localparam logic [2:0] OP_ELEM_LOAD = 3'd5;
    localparam logic [2:0] OP_SETTLE    = 3'd6;
    localparam logic [2:0] OP_EMIT      = 3'd7;

    // jump conditions
    localparam logic [2:0] C_NONE      = 3'd0;
    localparam logic [2:0] C_NO_ITEM   = 3'd1;
    localparam logic [2:0] C_START     = 3'd2;
    localparam logic [2:0] C_DIV_MORE  = 3'd3;
    localparam logic [2:0] C_NEXT_ELEM = 3'd4;
    localparam logic [2:0] C_UNSETTLED = 3'd5;

    // program steps
    localparam logic [2:0] S_WAIT      = 3'd0;
    localparam logic [2:0] S_DECODE    = 3'd1;
    localparam logic [2:0] S_DIV_INIT  = 3'd2;
    localparam logic [2:0] S_DIV_STEP  = 3'd3;
    localparam logic [2:0] S_ELEM_LOAD = 3'd4;
    localparam logic [2:0] S_SETTLE    = 3'd5;
    localparam logic [2:0] S_CHECK     = 3'd6;
    localparam logic [2:0] S_EMIT      = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] cond;
        logic [2:0] jmp;
        logic [2:0] nxt;
    } t_uword;

    function automatic t_uword f_urom(input logic [2:0] step);
        t_uword w;
        case (step)
            S_WAIT:      w = '{OP_TAKE,      C_NO_ITEM,   S_WAIT,     S_DECODE};
            S_DECODE:    w = '{OP_DECODE,    C_START,     S_DIV_INIT, S_SETTLE};
            S_DIV_INIT:  w = '{OP_DIV_INIT,  C_NONE,      S_WAIT,     S_DIV_STEP};
            S_DIV_STEP:  w = '{OP_DIV_STEP,  C_DIV_MORE,  S_DIV_STEP, S_ELEM_LOAD};
            S_ELEM_LOAD: w = '{OP_ELEM_LOAD, C_NONE,      S_WAIT,     S_SETTLE};
            S_SETTLE:    w = '{OP_SETTLE,    C_NEXT_ELEM, S_DIV_INIT, S_CHECK};
            S_CHECK:     w = '{OP_NONE,      C_UNSETTLED, S_SETTLE,   S_EMIT};
            S_EMIT:      w = '{OP_EMIT,      C_NONE,      S_WAIT,     S_WAIT};
            default:     w = '{OP_NONE,      C_NONE,      S_WAIT,     S_WAIT};
        endcase
        return w;
    endfunction

endpackage

/* src/morse_pulse_burst_keyer.sv */
// ----------------------------------------------------------------------------
// morse_pulse_burst_keyer
// Morse keyer whose dots and dashes are bursts of pulses, timed by tick items.
// ----------------------------------------------------------------------------
// Each input item is a millisecond tick, a character or a digit; each gives one
// result with the pin level for that tick, the busy flag and whether a send
// request started. A small control program steps a plain datapath, one item at
// a time: an item is taken only in the program's wait step with the output
// register free. For each element of a symbol, a restoring divider works out the
// pulse count from the dot or dash time and the pulse period (high plus low).
// Configuration is written through a plain write port while the block is idle;
// the user must keep to this, as the block itself does not enforce it.
module morse_pulse_burst_keyer
    import mpbk_pkg::*;
#(
    parameter int TIME_BITS = MPBK_TIME_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // func[1:0], code[9:2], zero pad
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // pin_level[0], busy_res[1], accepted[2]
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam logic [31:0] TMAX = (TIME_BITS >= 32) ? 32'hFFFF_FFFF
                                                      : ((32'd1 << TIME_BITS) - 32'd1);

    function automatic logic [TIME_BITS-1:0] f_tload(input logic [15:0] v);
        logic [31:0] w;
        w = {16'd0, v};
        if (w > TMAX) begin
            return TMAX[TIME_BITS-1:0];
        end
        return w[TIME_BITS-1:0];
    endfunction

    logic [15:0] r_dot, n_dot, r_dash, n_dash, r_egap, n_egap, r_wgap, n_wgap;
    logic [7:0]  r_phigh, n_phigh, r_plow, n_plow;

    logic [2:0]           r_upc, n_upc;
    logic [2:0]           r_phase, n_phase;
    logic [4:0]           r_pat, n_pat;
    logic [2:0]           r_total, n_total;
    logic [2:0]           r_pos, n_pos;
    logic [15:0]          r_pulses, n_pulses;
    logic [TIME_BITS-1:0] r_time, n_time;

    logic [1:0]  r_func, n_func;
    logic [7:0]  r_code, n_code;
    logic [15:0] r_dq, n_dq;
    logic [8:0]  r_rem, n_rem;
    logic [3:0]  r_div_cnt, n_div_cnt;
    logic        r_pin, n_pin, r_acc, n_acc;
    logic        r_ovalid, n_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata, n_odata;

    t_uword      w_uw;
    logic        w_fire, w_cond, w_ws, w_lower, w_upper, w_digit, w_start;
    logic [4:0]  w_lidx;
    logic [8:0]  w_period;
    logic [7:0]  w_pat_ext;
    logic [2:0]  w_pos_inc;
    logic [9:0]  w_trial;
    logic [15:0] w_count, w_pulses_dec;

    assign w_uw      = f_urom(r_upc);
    assign s_axis_tready = (r_upc == S_WAIT) && (!r_ovalid || m_axis_tready);
    assign w_fire    = s_axis_tvalid && s_axis_tready;
    assign w_period  = {1'b0, r_phigh} + {1'b0, r_plow};
    assign w_pat_ext = {3'b000, r_pat};
    assign w_pos_inc = r_pos + 3'd1;
    assign w_trial   = {r_rem, r_dq[15]};
    assign w_count   = (w_period == 9'd0) ? 16'd0 : r_dq;
    assign w_pulses_dec = r_pulses - 16'd1;

    always_comb begin
        w_ws    = (r_code inside {CH_SPACE, CH_NL, CH_TAB});
        w_lower = (r_code inside {[CH_LA:CH_LZ]});
        w_upper = (r_code inside {[CH_UA:CH_UZ]});
        w_digit = (r_code <= DIGIT_MAX);
        w_lidx  = w_lower ? 5'(r_code - CH_LA) : 5'(r_code - CH_UA);
        w_start = (r_phase == PH_IDLE) &&
                  (((r_func == FN_CHAR) && (w_lower || w_upper)) ||
                   ((r_func == FN_DIGIT) && w_digit));
    end

    always_comb begin
        case (w_uw.cond)
            C_NONE:      w_cond = 1'b0;
            C_NO_ITEM:   w_cond = !w_fire;
            C_START:     w_cond = w_start;
            C_DIV_MORE:  w_cond = (r_div_cnt != 4'd0);
            C_NEXT_ELEM: w_cond = (r_phase == PH_EGAP) && (r_time == '0) &&
                                  (w_pos_inc < r_total);
            C_UNSETTLED: w_cond = (r_phase != PH_IDLE) && (r_time == '0);
            default:     w_cond = 1'b0;
        endcase
    end

    always_comb begin
        n_dot = r_dot;   n_dash = r_dash;   n_egap = r_egap;
        n_wgap = r_wgap; n_phigh = r_phigh; n_plow = r_plow;
        n_upc = w_cond ? w_uw.jmp : w_uw.nxt;
        n_phase = r_phase; n_pat = r_pat; n_total = r_total; n_pos = r_pos;
        n_pulses = r_pulses; n_time = r_time;
        n_func = r_func; n_code = r_code;
        n_dq = r_dq; n_rem = r_rem; n_div_cnt = r_div_cnt;
        n_pin = r_pin; n_acc = r_acc;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_odata = r_odata;

        if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_DOT:   n_dot   = i_cfg_wdata;
                REG_DASH:  n_dash  = i_cfg_wdata;
                REG_EGAP:  n_egap  = i_cfg_wdata;
                REG_WGAP:  n_wgap  = i_cfg_wdata;
                REG_PHIGH: n_phigh = i_cfg_wdata[7:0];
                REG_PLOW:  n_plow  = i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end

        case (w_uw.op)
            OP_TAKE: begin
                n_func = s_axis_tdata[1:0];
                n_code = s_axis_tdata[9:2];
            end
            OP_DECODE: begin
                n_pin = 1'b0;
                n_acc = 1'b0;
                case (r_func)
                    FN_TICK: begin
                        if (r_phase != PH_IDLE) begin
                            n_pin  = (r_phase == PH_HIGH);
                            n_time = r_time - 1'b1;
                        end
                    end
                    FN_CHAR: begin
                        if (r_phase == PH_IDLE) begin
                            if (w_ws) begin
                                n_phase = PH_WGAP;
                                n_time  = f_tload(r_wgap);
                                n_acc   = 1'b1;
                            end else if (w_lower || w_upper) begin
                                n_pat   = LETTER_PAT[w_lidx];
                                n_total = LETTER_LEN[w_lidx];
                                n_pos   = 3'd0;
                                n_acc   = 1'b1;
                            end
                        end
                    end
                    FN_DIGIT: begin
                        if (r_phase == PH_IDLE && w_digit) begin
                            n_pat   = DIGIT_PAT[r_code[3:0]];
                            n_total = DIGIT_LEN;
                            n_pos   = 3'd0;
                            n_acc   = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            OP_DIV_INIT: begin
                n_dq      = w_pat_ext[r_pos] ? r_dash : r_dot;
                n_rem     = 9'd0;
                n_div_cnt = 4'(DIV_STEPS - 1);
            end
            OP_DIV_STEP: begin
                if (w_trial >= {1'b0, w_period}) begin
                    n_rem = 9'(w_trial - {1'b0, w_period});
                    n_dq  = {r_dq[14:0], 1'b1};
                end else begin
                    n_rem = w_trial[8:0];
                    n_dq  = {r_dq[14:0], 1'b0};
                end
                if (r_div_cnt != 4'd0) begin
                    n_div_cnt = r_div_cnt - 4'd1;
                end
            end
            OP_ELEM_LOAD: begin
                n_pulses = w_count;
                if (w_count != 16'd0) begin
                    n_phase = PH_HIGH;
                    n_time  = f_tload({8'd0, r_phigh});
                end else begin
                    n_phase = PH_EGAP;
                    n_time  = f_tload(r_egap);
                end
            end
            OP_SETTLE: begin
                if (r_phase != PH_IDLE && r_time == '0) begin
                    case (r_phase)
                        PH_HIGH: begin
                            n_phase = PH_LOW;
                            n_time  = f_tload({8'd0, r_plow});
                        end
                        PH_LOW: begin
                            n_pulses = w_pulses_dec;
                            if (w_pulses_dec != 16'd0) begin
                                n_phase = PH_HIGH;
                                n_time  = f_tload({8'd0, r_phigh});
                            end else begin
                                n_phase = PH_EGAP;
                                n_time  = f_tload(r_egap);
                            end
                        end
                        PH_EGAP: begin
                            n_pos = w_pos_inc;
                            if (!(w_pos_inc < r_total)) begin
                                n_phase = PH_IDLE;
                            end
                        end
                        default: n_phase = PH_IDLE;
                    endcase
                end
            end
            OP_EMIT: begin
                n_ovalid = 1'b1;
                n_odata  = {5'd0, r_acc, (r_phase != PH_IDLE), r_pin};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot    <= RST_DOT;
            r_dash   <= RST_DASH;
            r_egap   <= RST_EGAP;
            r_wgap   <= RST_WGAP;
            r_phigh  <= RST_PHIGH;
            r_plow   <= RST_PLOW;
            r_upc    <= S_WAIT;
            r_phase  <= PH_IDLE;
            r_pat    <= '0;
            r_total  <= '0;
            r_pos    <= '0;
            r_pulses <= '0;
            r_time   <= '0;
            r_div_cnt <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_dot    <= n_dot;
            r_dash   <= n_dash;
            r_egap   <= n_egap;
            r_wgap   <= n_wgap;
            r_phigh  <= n_phigh;
            r_plow   <= n_plow;
            r_upc    <= n_upc;
            r_phase  <= n_phase;
            r_pat    <= n_pat;
            r_total  <= n_total;
            r_pos    <= n_pos;
            r_pulses <= n_pulses;
            r_time   <= n_time;
            r_div_cnt <= n_div_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func  <= n_func;
        r_code  <= n_code;
        r_dq    <= n_dq;
        r_rem   <= n_rem;
        r_pin   <= n_pin;
        r_acc   <= n_acc;
        r_odata <= n_odata;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

`ifndef SYNTHESIS
    // settled state before a result goes out
    a_settled_at_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == S_EMIT) |-> ((r_phase == PH_IDLE) || (r_time != '0)))
        else $error("result emitted with a zero-length phase pending");

    a_high_has_pulses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_HIGH) || (r_phase == PH_LOW)) && (r_upc == S_EMIT)
        |-> (r_pulses != 16'd0))
        else $error("burst phase with no pulses left");

    a_pos_in_symbol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == S_EMIT) && (r_phase != PH_IDLE) && (r_phase != PH_WGAP)
        |-> (r_pos < r_total))
        else $error("element position beyond symbol length");

    a_emit_fills_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == S_EMIT) |=> r_ovalid)
        else $error("result lost at emit");
`endif

endmodule
